[hw/rtl/mlm_pkg.sv]
`default_nettype none
package mlm_pkg;
  localparam int SizeBits = 26;
  localparam int TimeBits = 48;
  localparam int PctBits = 7;
  localparam int CntBits = 32;
  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 32;
  localparam int QuoBits = 7;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_WD_ENABLE = 3'd0,
    CFG_WD_THRESH = 3'd1,
    CFG_CRIT_THR  = 3'd2,
    CFG_WARN_THR  = 3'd3,
    CFG_COOLDOWN  = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_EXT,
    ST_DIV_INT,
    ST_DIV_FRAG,
    ST_EMA,
    ST_COMMIT,
    ST_OUT
  } state_t;

  // division selector for the shared unit
  typedef enum logic [1:0] {
    DSEL_EXT  = 2'd0,
    DSEL_INT  = 2'd1,
    DSEL_FRAG = 2'd2,
    DSEL_EMA  = 2'd3
  } dsel_t;

  typedef struct packed {
    logic  load;
    logic  div_start;
    dsel_t div_sel;
    logic  div_step;
    logic  commit;
    logic  out_load;
  } ctl_t;

  typedef struct packed {
    logic  div_done;
    func_t func;
  } sts_t;

  typedef struct packed {
    logic [1:0]          func;
    logic [3:0]          stat_index;
    logic [SizeBits-1:0] ext_total;
    logic [SizeBits-1:0] ext_free;
    logic [SizeBits-1:0] int_total;
    logic [SizeBits-1:0] int_free;
    logic [SizeBits-1:0] int_largest;
    logic [TimeBits-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [PctBits-1:0] ext_used_pct;
    logic [PctBits-1:0] int_used_pct;
    logic [PctBits-1:0] int_frag_pct;
    logic               ext_present;
    logic [1:0]         level;
    logic [1:0]         alert;
    logic [CntBits-1:0] stat_value;
  } out_item_t;
endpackage
`default_nettype wire

[hw/rtl/mlm_if.sv]
`default_nettype none
interface mlm_in_if;
  logic valid;
  logic ready;
  mlm_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mlm_out_if;
  logic valid;
  logic ready;
  mlm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/memory_level_monitor.sv]
// memory_level_monitor
// in channel: one beat per request (sample, statistic read, statistic clear).
// out channel: exactly one result beat per request, in order.
// a sample runs three percentage divisions through one shared restoring
// divider, one quotient bit per cycle, then the ema update and the commit;
// the result beat is then offered on the out channel.
// read, clear and unused requests skip the divisions and the ema update.
// one request is in flight at a time; the next beat is taken in the cycle after
// the result beat has left, so a new request is never taken while a result
// is still pending.
// the result register holds its beat while out.ready is low; nothing is lost.
// cfg writes take effect at the edge where cfg_we is high and must be issued
// while the block is idle. a write to the watchdog enable also clears the
// last alert time.
// synchronous reset (rst_n low) restores the register defaults, clears all
// statistics and the last alert time, and drops out.valid.
`default_nettype none
module memory_level_monitor (
  input  wire logic clk,
  input  wire logic rst_n,
  mlm_in_if.sink    in_ch,
  mlm_out_if.source out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [mlm_pkg::CfgIdxBits-1:0]   cfg_index,
  input  wire logic [mlm_pkg::CfgDataBits-1:0]  cfg_data
);
  mlm_pkg::ctl_t ctl;
  mlm_pkg::sts_t sts;

  mlm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .ctl(ctl)
  );

  mlm_dp u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_data(in_ch.data), .out_data(out_ch.data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.data.int_used_pct <= 7'd100 &&
                     out_ch.data.ext_used_pct <= 7'd100 &&
                     out_ch.data.int_frag_pct <= 7'd100)
    else $error("percentage out of range");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("accepting while a result is pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result dropped while stalled");
endmodule
`default_nettype wire

[hw/rtl/mlm_ctrl.sv]
`default_nettype none
module mlm_ctrl (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire mlm_pkg::sts_t sts,
  output mlm_pkg::ctl_t   ctl
);
  mlm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    ctl.div_sel = mlm_pkg::DSEL_EXT;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      mlm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          state_nxt = mlm_pkg::ST_DIV_EXT;
        end
      end
      mlm_pkg::ST_DIV_EXT: begin
        if (sts.func != mlm_pkg::FUNC_SAMPLE) begin
          state_nxt = mlm_pkg::ST_COMMIT;
        end else begin
          ctl.div_sel = mlm_pkg::DSEL_EXT;
          ctl.div_step = 1'b1;
          if (sts.div_done) begin
            ctl.div_start = 1'b1;
            state_nxt = mlm_pkg::ST_DIV_INT;
          end
        end
      end
      mlm_pkg::ST_DIV_INT: begin
        ctl.div_sel = mlm_pkg::DSEL_INT;
        ctl.div_step = 1'b1;
        if (sts.div_done) begin
          ctl.div_start = 1'b1;
          state_nxt = mlm_pkg::ST_DIV_FRAG;
        end
      end
      mlm_pkg::ST_DIV_FRAG: begin
        ctl.div_sel = mlm_pkg::DSEL_FRAG;
        ctl.div_step = 1'b1;
        if (sts.div_done) begin
          ctl.div_start = 1'b1;
          state_nxt = mlm_pkg::ST_EMA;
        end
      end
      mlm_pkg::ST_EMA: begin
        ctl.div_sel = mlm_pkg::DSEL_EMA;
        ctl.div_step = 1'b1;
        state_nxt = mlm_pkg::ST_COMMIT;
      end
      mlm_pkg::ST_COMMIT: begin
        ctl.commit = 1'b1;
        ctl.out_load = 1'b1;
        state_nxt = mlm_pkg::ST_OUT;
      end
      mlm_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = mlm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mlm_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[hw/rtl/mlm_dp.sv]
`default_nettype none
module mlm_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire mlm_pkg::ctl_t                ctl,
  output mlm_pkg::sts_t                     sts,
  input  wire mlm_pkg::in_item_t            in_data,
  output mlm_pkg::out_item_t                out_data,
  input  wire logic                         cfg_we,
  input  wire logic [mlm_pkg::CfgIdxBits-1:0]  cfg_index,
  input  wire logic [mlm_pkg::CfgDataBits-1:0] cfg_data
);
  localparam int SB = mlm_pkg::SizeBits;
  localparam int TB = mlm_pkg::TimeBits;
  localparam int PB = mlm_pkg::PctBits;
  localparam int CB = mlm_pkg::CntBits;
  // dividend part*100 fits SB+7 bits
  localparam int NB = SB + 7;
  localparam int QB = mlm_pkg::QuoBits;
  localparam logic [SB-1:0] SizeOnes = '1;
  localparam logic [CB-1:0] CntOnes = '1;

  mlm_pkg::in_item_t item_r;

  logic wd_en_r;
  logic [SB-1:0] wd_thr_r, crit_thr_r, warn_thr_r;
  logic [31:0] cool_r;
  logic [TB-1:0] last_alert_r;

  logic [CB-1:0] upd_cnt_r, crit_cnt_r, warn_cnt_r;
  logic [SB-1:0] if_min_r, if_max_r, if_avg_r, ef_min_r, ef_max_r, ef_avg_r;
  logic [PB-1:0] fr_min_r, fr_max_r, fr_avg_r;

  logic [PB-1:0] ext_pct_r, int_pct_r, frag_pct_r;
  logic [SB-1:0] if_ema_r, ef_ema_r;
  logic [PB-1:0] fr_ema_r;

  // shared restoring divider, one quotient bit a cycle
  logic [NB-1:0] rem_r;
  logic [SB-1:0] dvs_r;
  logic [QB-1:0] quo_r;
  logic [NB-1:0] dvd_r;
  logic [2:0]    cnt_r;
  logic          dv_busy_r;

  logic [SB-1:0] part, whole;
  logic [NB-1:0] part100;
  logic [NB:0]   trial;
  logic [NB-1:0] rem_sh;

  // ema by reciprocal: (9a+x)/10, value < 10*2^SB
  logic [SB+3:0] ema_if_s, ema_ef_s;
  logic [PB+3:0] ema_fr_s;

  function automatic logic [SB-1:0] sat_sub(input logic [SB-1:0] a, input logic [SB-1:0] b);
    sat_sub = (a > b) ? a - b : '0;
  endfunction

  function automatic logic [SB-1:0] div10(input logic [SB+3:0] v);
    logic [2*(SB+4)-1:0] prod;
    logic [SB+3:0] q, r;
    // floor(v*M/2^k), then one correction step
    prod = v * ((SB+4)'((64'd1 << (SB + 4)) / 64'd10));
    q = prod[2*(SB+4)-1:SB+4];
    r = v - q * (SB+4)'(10);
    if (r >= (SB+4)'(10)) q = q + 1'b1;
    div10 = q[SB-1:0];
  endfunction

  always_comb begin
    case (ctl.div_sel)
      mlm_pkg::DSEL_EXT: begin
        part = sat_sub(item_r.ext_total, item_r.ext_free);
        whole = item_r.ext_total;
      end
      mlm_pkg::DSEL_INT: begin
        part = sat_sub(item_r.int_total, item_r.int_free);
        whole = item_r.int_total;
      end
      default: begin
        part = sat_sub(item_r.int_free, item_r.int_largest);
        whole = item_r.int_free;
      end
    endcase
    part100 = NB'(part) * NB'(100);
    rem_sh = {rem_r[NB-2:0], dvd_r[NB-1]};
    trial = {1'b0, rem_sh} - {{(NB-SB+1){1'b0}}, dvs_r};
  end

  assign sts.div_done = dv_busy_r && (cnt_r == 3'd0);
  assign sts.func = mlm_pkg::func_t'(item_r.func);

  // quotient is below 2^7, so top bits of dividend start in remainder
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (ctl.load || ctl.div_start) begin
      dv_busy_r <= 1'b0;
    end else if (ctl.div_step && !dv_busy_r) begin
      dv_busy_r <= 1'b1;
      cnt_r <= 3'd7;
    end else if (ctl.div_step && cnt_r != 3'd0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_step && !dv_busy_r) begin
      rem_r <= NB'(part100 >> QB);
      dvd_r <= part100 << (NB - QB);
      dvs_r <= whole;
      quo_r <= '0;
    end else if (ctl.div_step && cnt_r != 3'd1 && cnt_r != 3'd0 || (cnt_r == 3'd1 && ctl.div_step)) begin
      dvd_r <= dvd_r << 1;
      if (!trial[NB]) begin
        rem_r <= trial[NB-1:0];
        quo_r <= {quo_r[QB-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[QB-2:0], 1'b0};
      end
    end
    if (ctl.div_start) begin
      case (ctl.div_sel)
        mlm_pkg::DSEL_EXT: ext_pct_r <= (whole == '0) ? '0 : quo_r;
        mlm_pkg::DSEL_INT: int_pct_r <= (whole == '0) ? '0 : quo_r;
        default: frag_pct_r <= (whole == '0) ? PB'(100) : quo_r;
      endcase
    end
  end

  always_comb begin
    ema_if_s = ((SB+4)'(if_avg_r) << 3) + (SB+4)'(if_avg_r) + (SB+4)'(item_r.int_free);
    ema_ef_s = ((SB+4)'(ef_avg_r) << 3) + (SB+4)'(ef_avg_r) + (SB+4)'(item_r.ext_free);
    ema_fr_s = ((PB+4)'(fr_avg_r) << 3) + (PB+4)'(fr_avg_r) + (PB+4)'(frag_pct_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) item_r <= in_data;
    if (ctl.div_sel == mlm_pkg::DSEL_EMA && ctl.div_step) begin
      if_ema_r <= div10(ema_if_s);
      ef_ema_r <= div10(ema_ef_s);
      fr_ema_r <= PB'(div10((SB+4)'(ema_fr_s)));
    end
  end

  logic crit, warn, present, first, alert_ok;
  logic [TB-1:0] gap;
  logic [1:0] alert;
  logic [CB-1:0] stat;

  always_comb begin
    crit = item_r.int_free < crit_thr_r;
    warn = item_r.int_free < warn_thr_r;
    present = item_r.ext_total != '0;
    first = upd_cnt_r == '0;
    gap = item_r.now_ms - last_alert_r;
    alert_ok = wd_en_r && (item_r.int_free < wd_thr_r) && (gap >= TB'(cool_r));
    alert = alert_ok ? (crit ? 2'd2 : 2'd1) : 2'd0;
    case (item_r.stat_index)
      4'd0: stat = upd_cnt_r;
      4'd1: stat = CB'(if_min_r);
      4'd2: stat = CB'(if_max_r);
      4'd3: stat = CB'(if_avg_r);
      4'd4: stat = CB'(fr_min_r);
      4'd5: stat = CB'(fr_max_r);
      4'd6: stat = CB'(fr_avg_r);
      4'd7: stat = CB'(ef_min_r);
      4'd8: stat = CB'(ef_max_r);
      4'd9: stat = CB'(ef_avg_r);
      4'd10: stat = crit_cnt_r;
      4'd11: stat = warn_cnt_r;
      default: stat = '0;
    endcase
  end

  logic is_smp;
  assign is_smp = item_r.func == mlm_pkg::FUNC_SAMPLE;

  mlm_pkg::out_item_t out_nxt;

  always_comb begin
    out_nxt = '0;
    if (is_smp) begin
      out_nxt.ext_used_pct = ext_pct_r;
      out_nxt.int_used_pct = int_pct_r;
      out_nxt.int_frag_pct = frag_pct_r;
      out_nxt.ext_present = present;
      out_nxt.level = crit ? 2'd2 : (warn ? 2'd1 : 2'd0);
      out_nxt.alert = alert;
    end else if (item_r.func == mlm_pkg::FUNC_READ) begin
      out_nxt.stat_value = stat;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) out_data <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wd_en_r <= 1'b0;
      wd_thr_r <= SB'(15000);
      crit_thr_r <= SB'(10240);
      warn_thr_r <= SB'(30720);
      cool_r <= 32'd30000;
      last_alert_r <= '0;
    end else if (cfg_we) begin
      case (mlm_pkg::cfg_idx_t'(cfg_index))
        mlm_pkg::CFG_WD_ENABLE: begin
          wd_en_r <= cfg_data[0];
          last_alert_r <= '0;
        end
        mlm_pkg::CFG_WD_THRESH: wd_thr_r <= cfg_data[SB-1:0];
        mlm_pkg::CFG_CRIT_THR: crit_thr_r <= cfg_data[SB-1:0];
        mlm_pkg::CFG_WARN_THR: warn_thr_r <= cfg_data[SB-1:0];
        mlm_pkg::CFG_COOLDOWN: cool_r <= cfg_data;
        default: ;
      endcase
    end else if (ctl.commit && is_smp && alert_ok) begin
      last_alert_r <= item_r.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (ctl.commit && item_r.func == mlm_pkg::FUNC_CLEAR)) begin
      upd_cnt_r <= '0;
      if_min_r <= SizeOnes;
      if_max_r <= '0;
      if_avg_r <= '0;
      fr_min_r <= '1;
      fr_max_r <= '0;
      fr_avg_r <= '0;
      ef_min_r <= SizeOnes;
      ef_max_r <= '0;
      ef_avg_r <= '0;
      crit_cnt_r <= '0;
      warn_cnt_r <= '0;
    end else if (ctl.commit && is_smp) begin
      if (upd_cnt_r != CntOnes) upd_cnt_r <= upd_cnt_r + 1'b1;
      if (item_r.int_free < if_min_r) if_min_r <= item_r.int_free;
      if (item_r.int_free > if_max_r) if_max_r <= item_r.int_free;
      if (frag_pct_r < fr_min_r) fr_min_r <= frag_pct_r;
      if (frag_pct_r > fr_max_r) fr_max_r <= frag_pct_r;
      if_avg_r <= first ? item_r.int_free : if_ema_r;
      fr_avg_r <= first ? frag_pct_r : fr_ema_r;
      if (present) begin
        if (item_r.ext_free < ef_min_r) ef_min_r <= item_r.ext_free;
        if (item_r.ext_free > ef_max_r) ef_max_r <= item_r.ext_free;
        ef_avg_r <= first ? item_r.ext_free : ef_ema_r;
      end
      if (crit && crit_cnt_r != CntOnes) crit_cnt_r <= crit_cnt_r + 1'b1;
      if (warn && warn_cnt_r != CntOnes) warn_cnt_r <= warn_cnt_r + 1'b1;
    end
  end
endmodule
`default_nettype wire
